// ----- rtl/core/agp_pkg.sv -----
// Shared types, constants and the PEC15 table function for the readback checker.
package agp_pkg;

    // Frame layout
    localparam int GROUP_BYTES = 6;
    localparam int MAX_CHIPS   = 8;
    localparam logic [2:0] POS_CODE_HI = 3'd6;
    localparam logic [2:0] POS_CODE_LO = 3'd7;

    // PEC15 code
    localparam logic [15:0] PEC_SEED = 16'h0010;
    localparam logic [14:0] PEC_POLY = 15'h4599;
    localparam logic [11:0] RAW_MASK = 12'hFFF;

    // Millivolt scaling: floor(p / 1000) == (p * DIV_RECIP) >> DIV_SHIFT for p < 2^22
    localparam int          DIV_SHIFT = 32;
    localparam logic [22:0] DIV_RECIP = 23'd4294968;
    localparam logic [11:0] MV_MAX    = 12'd4095;

    // Group read operations
    localparam logic [2:0] OP_CELL_A = 3'd0;
    localparam logic [2:0] OP_CELL_B = 3'd1;
    localparam logic [2:0] OP_CELL_C = 3'd2;
    localparam logic [2:0] OP_CELL_D = 3'd3;
    localparam logic [2:0] OP_AUX_A  = 3'd4;
    localparam logic [2:0] OP_AUX_B  = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] REG_LSB_MICROVOLTS = 2'd0;
    localparam logic [1:0] REG_CELLS_PER_CHIP = 2'd1;
    localparam logic [1:0] REG_SERIES_CELLS   = 2'd2;

    // Queue depths
    localparam int JOB_DEPTH_DEF = 2;
    localparam int RES_DEPTH_DEF = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic [2:0] chip_index;
        logic [2:0] operation;
    } t_item;

    typedef struct packed {
        logic [6:0]  value_index;
        logic [11:0] millivolts;
        logic        is_aux;
        logic        pec_error;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [9:0] lsb_microvolts;
        logic [3:0] cells_per_chip;
        logic [6:0] series_cells;
    } t_cfg;

    // One classified frame: which slots to emit, their indexes and raw readings
    typedef struct packed {
        logic             pec_error;
        logic             is_aux;
        logic [2:0]       mask;
        logic [2:0][6:0]  idx;
        logic [2:0][11:0] raw;
    } t_job;

    // PEC15 table entry
    function automatic logic [14:0] pec_entry(input logic [7:0] idx);
        logic [14:0] rem;
        rem = {idx, 7'd0};
        for (int b = 0; b < 8; b++) begin
            if (rem[14]) begin
                rem = {rem[13:0], 1'b0} ^ PEC_POLY;
            end else begin
                rem = {rem[13:0], 1'b0};
            end
        end
        return rem;
    endfunction

endpackage

// ----- rtl/core/afe_group_pec_check_and_scale.sv -----
// Top level: register-group readback checker and millivolt scaler.
//
// Usage: response bytes enter as words on the push/full side, one byte per word:
// six data bytes, then the received PEC high and low bytes. frame_start marks
// data byte 0. On the closing byte the frame is checked; a mismatch gives a
// single error word, a match gives up to three indexed millivolt words, the
// final one flagged last. Results leave on the empty/pop side, oldest first.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data while idle.
//
// Throughput: one byte per cycle while full is low. Results drain one per cycle while popped.
// The first result of a frame passes the job queue, the product register of the
// scaler and the result queue before it is on the output.
// full rises only while the job queue holds JOB_DEPTH frames, which happens
// when the receiver stops popping and the result queue (RES_DEPTH words) fills.
// A stalled result holds on o_result until popped; nothing is dropped.
// Reset: both queues empty, byte position 0, code seeded, registers to defaults.
module afe_group_pec_check_and_scale #(
    parameter int JOB_DEPTH = agp_pkg::JOB_DEPTH_DEF,
    parameter int RES_DEPTH = agp_pkg::RES_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    input  agp_pkg::t_item   i_item,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output agp_pkg::t_result o_result,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [9:0]       i_cfg_data
);
    import agp_pkg::*;

    t_cfg    r_cfg;
    logic    accept;
    logic    job_push, job_full, job_empty, job_pop;
    t_job    job_in, job_out;
    logic [$clog2(JOB_DEPTH+1)-1:0] job_count;
    logic    res_push, res_full;
    t_result res_in, res_out;
    logic [$clog2(RES_DEPTH+1)-1:0] res_count;
    logic [$bits(t_job)-1:0]    job_bits;
    logic [$bits(t_result)-1:0] res_bits;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lsb_microvolts <= 10'd100;
            r_cfg.cells_per_chip <= 4'd12;
            r_cfg.series_cells   <= 7'd12;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LSB_MICROVOLTS: r_cfg.lsb_microvolts <= i_cfg_data;
                REG_CELLS_PER_CHIP: r_cfg.cells_per_chip <= i_cfg_data[3:0];
                REG_SERIES_CELLS:   r_cfg.series_cells   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign full   = job_full;
    assign accept = push && !job_full;

    agp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .i_cfg      (r_cfg),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    // Job queue between front and back
    agp_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_data  (job_bits),
        .o_count (job_count)
    );
    assign job_out = t_job'(job_bits);

    agp_back #(
        .RES_DEPTH (RES_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_res_count (res_count),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // Result queue to the receiver
    agp_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_bits),
        .o_count (res_count)
    );
    assign res_out  = t_result'(res_bits);
    assign o_result = res_out;

    // Scaler credit must keep the result queue from overflowing
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result word pushed into full queue");

    // Front only pushes a job when the byte was taken, so never into a full queue
    a_job_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> !job_full)
        else $error("job pushed into full queue");

    // A job stays at the head until its last slot issues
    a_job_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |=> res_push && res_in.last)
        else $error("job retired without a last word");

    // An error word is always the only and final word of its frame
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && res_out.pec_error) |-> (res_out.last && res_out.millivolts == '0))
        else $error("error word not last or not zero");

    // Job count bookkeeping stays within depth
    a_job_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_count <= ($clog2(JOB_DEPTH+1))'(JOB_DEPTH))
        else $error("job queue count out of range");

endmodule

// ----- rtl/core/agp_fifo.sv -----
// Small register-based word queue with occupancy count.
module agp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    output logic                         o_full,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic [WIDTH-1:0]             o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- rtl/core/agp_front.sv -----
// Front end: byte framing, PEC15 check and classification of each frame into a job.
module agp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  agp_pkg::t_item i_item,
    input  agp_pkg::t_cfg  i_cfg,
    output logic          o_job_push,
    output agp_pkg::t_job  o_job
);
    import agp_pkg::*;

    logic [2:0]  r_pos, n_pos;
    logic [15:0] r_code, n_code;
    logic [7:0]  r_code_hi, n_code_hi;
    logic [7:0]  r_held [GROUP_BYTES];

    logic [2:0]  pos_eff;
    logic [15:0] code_eff;
    logic [7:0]  tab_idx;
    logic [15:0] computed, received;
    logic [2:0][11:0] raw;
    logic [2:0]  cell_mask;
    logic [2:0][6:0] cell_idx;
    logic [6:0]  aux_base;
    logic [3:0]  slot;
    logic [7:0]  gidx;
    t_job        job;
    logic        job_push;

    assign pos_eff  = i_item.frame_start ? 3'd0 : r_pos;
    assign code_eff = i_item.frame_start ? PEC_SEED : r_code;
    assign tab_idx  = code_eff[14:7] ^ i_item.data_byte;
    assign computed = {code_eff[14:0], 1'b0};
    assign received = {r_code_hi, i_item.data_byte};
    assign aux_base = 7'(i_item.chip_index) * 7'd5;

    // Little-endian readings from held bytes
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            raw[c] = {r_held[2*c+1][3:0], r_held[2*c]} & RAW_MASK;
        end
    end

    // Cell slots: skip past cells_per_chip and past the pack's last cell
    always_comb begin
        cell_mask = '0;
        cell_idx  = '0;
        slot      = '0;
        gidx      = '0;
        for (int c = 0; c < 3; c++) begin
            slot = 4'(i_item.operation[1:0]) * 4'd3 + 4'(c);
            gidx = 8'(i_item.chip_index) * 8'(i_cfg.cells_per_chip) + 8'(slot);
            cell_idx[c]  = gidx[6:0];
            cell_mask[c] = (slot < i_cfg.cells_per_chip) &&
                           (gidx < 8'(i_cfg.series_cells));
        end
    end

    // Per-byte framing and job build on the closing byte
    always_comb begin
        n_pos     = r_pos;
        n_code    = r_code;
        n_code_hi = r_code_hi;
        job       = '0;
        job_push  = 1'b0;
        if (i_accept) begin
            if (pos_eff < 3'(GROUP_BYTES)) begin
                n_code = {code_eff[7:0], 8'd0} ^ {1'b0, pec_entry(tab_idx)};
                n_pos  = pos_eff + 1'b1;
            end else if (pos_eff == POS_CODE_HI) begin
                n_code    = code_eff;
                n_code_hi = i_item.data_byte;
                n_pos     = POS_CODE_LO;
            end else begin
                n_pos  = '0;
                n_code = PEC_SEED;
                if ({1'b0, i_item.chip_index} < 4'(MAX_CHIPS)) begin
                    if (computed != received) begin
                        // error word: one zero-valued slot
                        job.pec_error = 1'b1;
                        job.mask      = 3'b001;
                        job_push      = 1'b1;
                    end else begin
                        job.raw = raw;
                        unique case (i_item.operation) inside
                            OP_CELL_A, OP_CELL_B, OP_CELL_C, OP_CELL_D: begin
                                job.mask = cell_mask;
                                job.idx  = cell_idx;
                            end
                            OP_AUX_A: begin
                                job.is_aux = 1'b1;
                                job.mask   = 3'b111;
                                for (int c = 0; c < 3; c++) begin
                                    job.idx[c] = aux_base + 7'(c);
                                end
                            end
                            OP_AUX_B: begin
                                job.is_aux = 1'b1;
                                job.mask   = 3'b011;
                                for (int c = 0; c < 3; c++) begin
                                    job.idx[c] = aux_base + 7'd3 + 7'(c);
                                end
                            end
                            default: begin
                                job.mask = '0;
                            end
                        endcase
                        job_push = (job.mask != '0);
                    end
                end
            end
        end
    end

    assign o_job      = job;
    assign o_job_push = job_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_code    <= PEC_SEED;
            r_code_hi <= '0;
        end else begin
            r_pos     <= n_pos;
            r_code    <= n_code;
            r_code_hi <= n_code_hi;
        end
    end

    // Data byte hold
    always_ff @(posedge i_clk) begin
        if (i_accept && (pos_eff < 3'(GROUP_BYTES))) begin
            r_held[pos_eff] <= i_item.data_byte;
        end
    end

endmodule

// ----- rtl/core/agp_back.sv -----
// Back end: walks each job's slots, scales readings to millivolts, feeds the result queue.
module agp_back #(
    parameter int RES_DEPTH = agp_pkg::RES_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  agp_pkg::t_cfg                   i_cfg,
    input  logic                            i_job_empty,
    input  agp_pkg::t_job                   i_job,
    output logic                            o_job_pop,
    input  logic [$clog2(RES_DEPTH+1)-1:0]  i_res_count,
    output logic                            o_res_push,
    output agp_pkg::t_result                o_res
);
    import agp_pkg::*;

    localparam int CW = $clog2(RES_DEPTH + 1);

    logic [2:0]  r_done;
    logic [2:0]  rem, sel;
    logic        is_last, credit, issue;
    logic [11:0] sel_raw;
    logic [6:0]  sel_idx;
    logic [21:0] prod;

    logic        r_a_valid;
    logic [21:0] r_a_prod;
    logic [6:0]  r_a_idx;
    logic        r_a_aux, r_a_err, r_a_last;

    logic [44:0] q_full;
    logic [12:0] q;
    t_result     res;

    // Slot pick: lowest slot not yet issued
    assign rem     = i_job.mask & ~r_done;
    assign sel     = rem & (~rem + 1'b1);
    assign is_last = ((rem & ~sel) == '0);
    assign credit  = ({1'b0, i_res_count} + (CW+1)'(r_a_valid)) < (CW+1)'(RES_DEPTH);
    assign issue   = !i_job_empty && credit && (rem != '0);
    assign o_job_pop = issue && is_last;

    always_comb begin
        sel_raw = '0;
        sel_idx = '0;
        for (int c = 0; c < 3; c++) begin
            if (sel[c]) begin
                sel_raw = i_job.raw[c];
                sel_idx = i_job.idx[c];
            end
        end
    end

    assign prod = 22'(sel_raw) * 22'(i_cfg.lsb_microvolts);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done    <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= issue;
            if (issue) begin
                r_done <= is_last ? 3'b000 : (r_done | sel);
            end
        end
    end

    // Product stage
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_a_prod <= prod;
            r_a_idx  <= sel_idx;
            r_a_aux  <= i_job.is_aux;
            r_a_err  <= i_job.pec_error;
            r_a_last <= is_last;
        end
    end

    // Divide by 1000 through the reciprocal, then saturate
    assign q_full = 45'(r_a_prod) * 45'(DIV_RECIP);
    assign q      = q_full[44:DIV_SHIFT];

    always_comb begin
        res.value_index = r_a_idx;
        res.millivolts  = (q > 13'(MV_MAX)) ? MV_MAX : q[11:0];
        res.is_aux      = r_a_aux;
        res.pec_error   = r_a_err;
        res.last        = r_a_last;
    end

    assign o_res_push = r_a_valid;
    assign o_res      = res;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the register-group readback PEC checker and scaler.
`timescale 1ns / 1ps

module testbench;
    import agp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_GAP        = 16;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_FRAMES   = 6;

    // DUT ports
    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       push;
    t_item      i_item;
    logic       full;
    logic       empty;
    logic       pop = 1'b0;
    t_result    o_result;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [9:0] i_cfg_data;

    afe_group_pec_check_and_scale dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Predictor copy of configuration and frame state
    int unsigned cfg_lsb_uv;
    int unsigned cfg_cells_per_chip;
    int unsigned cfg_series_cells;
    int unsigned rx_pos;
    logic [14:0] rx_code;
    logic [7:0]  rx_held [GROUP_BYTES];
    logic [7:0]  rx_code_hi;

    // Readings still owed by the DUT, oldest first
    t_result pending_readings[$];

    // Traffic shaping
    bit tx_no_idle;
    bit rx_no_stall;

    // Statistics
    int unsigned n_bytes;
    int unsigned n_stray_bytes;
    int unsigned n_frames;
    int unsigned n_settings;
    int unsigned n_results;
    int unsigned n_error_words;
    int unsigned n_mismatches;
    int unsigned pop_wait;
    int unsigned idle_cycles;

    // Bit-serial PEC15, MSB first
    function automatic logic [14:0] pec15_update(input logic [14:0] code, input logic [7:0] b);
        logic fb;
        for (int k = 7; k >= 0; k--) begin
            fb   = b[k] ^ code[14];
            code = {code[13:0], 1'b0};
            if (fb) begin
                code = code ^ PEC_POLY;
            end
        end
        return code;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    // Scaled reading for one slot of the held data
    function automatic t_result make_reading(input int unsigned idx, input int slot,
                                             input logic aux);
        t_result     r;
        int unsigned raw;
        int unsigned mv;
        raw = {rx_held[2*slot+1], rx_held[2*slot]} & RAW_MASK;
        mv  = raw * cfg_lsb_uv / 1000;
        if (mv > MV_MAX) begin
            mv = MV_MAX;
        end
        r             = '0;
        r.value_index = 7'(idx);
        r.millivolts  = 12'(mv);
        r.is_aux      = aux;
        return r;
    endfunction

    // Advance the frame state by one byte and queue the readings it causes
    task automatic predict_readback(input t_item it);
        logic [15:0] computed;
        logic [15:0] received;
        t_result     batch[$];
        t_result     r;
        int unsigned slot;
        int unsigned gidx;
        if (it.frame_start) begin
            rx_pos  = 0;
            rx_code = 15'(PEC_SEED);
        end
        if (rx_pos < GROUP_BYTES) begin
            rx_code         = pec15_update(rx_code, it.data_byte);
            rx_held[rx_pos] = it.data_byte;
            rx_pos++;
        end else if (rx_pos == GROUP_BYTES) begin
            rx_code_hi = it.data_byte;
            rx_pos++;
        end else begin
            // closing byte; chip index is 3 bits so it is always below MAX_CHIPS
            computed = {rx_code, 1'b0};
            received = {rx_code_hi, it.data_byte};
            rx_pos   = 0;
            rx_code  = 15'(PEC_SEED);
            if (computed != received) begin
                r           = '0;
                r.pec_error = 1'b1;
                batch.push_back(r);
            end else if (it.operation <= OP_CELL_D) begin
                for (int c = 0; c < 3; c++) begin
                    slot = it.operation * 3 + c;
                    if (slot < cfg_cells_per_chip) begin
                        gidx = it.chip_index * cfg_cells_per_chip + slot;
                        if (gidx < cfg_series_cells) begin
                            batch.push_back(make_reading(gidx, c, 1'b0));
                        end
                    end
                end
            end else if (it.operation == OP_AUX_A) begin
                for (int c = 0; c < 3; c++) begin
                    batch.push_back(make_reading(it.chip_index * 5 + c, c, 1'b1));
                end
            end else if (it.operation == OP_AUX_B) begin
                for (int c = 0; c < 2; c++) begin
                    batch.push_back(make_reading(it.chip_index * 5 + 3 + c, c, 1'b1));
                end
            end
            // undefined operations give nothing
            foreach (batch[k]) begin
                r      = batch[k];
                r.last = (k == batch.size() - 1);
                pending_readings.push_back(r);
            end
        end
    endtask

    // Offer one byte after a random gap; returns at the edge that takes it
    task automatic send_byte(input t_item it);
        int unsigned gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        predict_readback(it);
        n_bytes++;
    endtask

    // Six data bytes and their code, optionally corrupted
    task automatic send_frame(input logic [5:0][7:0] data, input logic [2:0] chip,
                              input logic [2:0] op, input bit with_start,
                              input logic [15:0] corrupt);
        logic [14:0] code;
        logic [15:0] sent_code;
        t_item       it;
        code = 15'(PEC_SEED);
        for (int k = 0; k < GROUP_BYTES; k++) begin
            code = pec15_update(code, data[k]);
        end
        sent_code = {code, 1'b0} ^ corrupt;
        for (int k = 0; k < GROUP_BYTES + 2; k++) begin
            if (k < GROUP_BYTES) begin
                it.data_byte = data[k];
            end else if (k == POS_CODE_HI) begin
                it.data_byte = sent_code[15:8];
            end else begin
                it.data_byte = sent_code[7:0];
            end
            it.frame_start = (k == 0) && with_start;
            // chip and op only matter on the closing byte
            it.chip_index  = (k == POS_CODE_LO) ? chip : 3'($urandom_range(0, 7));
            it.operation   = (k == POS_CODE_LO) ? op : 3'($urandom_range(0, 7));
            send_byte(it);
        end
        n_frames++;
    endtask

    // Stop sending and let every owed reading come out
    task automatic wait_for_drain();
        push <= 1'b0;
        while (pending_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_settings(input int unsigned lsb_uv, input int unsigned cpc,
                                  input int unsigned series);
        wait_for_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_LSB_MICROVOLTS;
        i_cfg_data  <= 10'(lsb_uv);
        @(posedge i_clk);
        cfg_lsb_uv  = lsb_uv;
        i_cfg_index <= REG_CELLS_PER_CHIP;
        i_cfg_data  <= 10'(cpc);
        @(posedge i_clk);
        cfg_cells_per_chip = cpc;
        i_cfg_index <= REG_SERIES_CELLS;
        i_cfg_data  <= 10'(series);
        @(posedge i_clk);
        cfg_series_cells = series;
        i_cfg_we    <= 1'b0;
        n_settings++;
    endtask

    // Mostly good frames; some corrupted codes and some broken partial frames
    task automatic run_random_frames(input int count);
        logic [5:0][7:0] data;
        logic [15:0]     corrupt;
        t_item           junk;
        int unsigned     n_junk;
        bit              start;
        for (int f = 0; f < count; f++) begin
            if ($urandom_range(0, 9) == 0) begin
                n_junk = $urandom_range(1, 7);
                repeat (n_junk) begin
                    junk.data_byte   = rand_byte();
                    junk.frame_start = ($urandom_range(0, 3) == 0);
                    junk.chip_index  = 3'($urandom_range(0, 7));
                    junk.operation   = 3'($urandom_range(0, 7));
                    send_byte(junk);
                    n_stray_bytes++;
                end
            end
            for (int k = 0; k < GROUP_BYTES; k++) begin
                data[k] = rand_byte();
            end
            corrupt = ($urandom_range(0, 9) == 0) ? 16'(1 << $urandom_range(0, 15)) : 16'h0;
            // resync needs frame_start; otherwise either form works
            start = (rx_pos != 0) ? 1'b1 : 1'($urandom_range(0, 1));
            send_frame(data, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), start,
                       corrupt);
        end
    endtask

    // Extreme data, frame without frame_start, undefined op, code error
    task automatic test_directed_frames();
        logic [5:0][7:0] data;
        send_frame({6{8'hFF}}, 3'd0, OP_CELL_A, 1'b1, 16'h0);
        send_frame({6{8'h00}}, 3'd7, 3'd7, 1'b0, 16'h0);
        for (int k = 0; k < GROUP_BYTES; k++) begin
            data[k] = rand_byte();
        end
        send_frame(data, 3'd7, OP_AUX_B, 1'b1, 16'h0001);
    endtask

    // Smallest settings, then 1000 uV per LSB with 12x8 cells; the smallest truncate almost every cell
    task automatic test_config_extremes();
        write_settings(1, 1, 1);
        run_random_frames(PHASE_FRAMES);
        write_settings(1000, 12, 96);
        run_random_frames(PHASE_FRAMES);
    endtask

    // Sender never idles while the receiver stalls, so full gets exercised
    task automatic test_result_backpressure();
        write_settings($urandom_range(1, 1000), 12, 96);
        tx_no_idle = 1'b1;
        run_random_frames(PHASE_FRAMES);
        tx_no_idle = 1'b0;
    endtask

    task automatic test_back_to_back();
        tx_no_idle  = 1'b1;
        rx_no_stall = 1'b1;
        run_random_frames(PHASE_FRAMES);
        tx_no_idle  = 1'b0;
        rx_no_stall = 1'b0;
    endtask

    task automatic test_random_settings();
        repeat (2) begin
            write_settings($urandom_range(1, 1000), $urandom_range(1, 12),
                           $urandom_range(1, 96));
            run_random_frames(PHASE_FRAMES);
        end
    endtask

    // Compare one popped word with the oldest owed reading
    function automatic void check_reading(input t_result got);
        t_result want;
        n_results++;
        if (got.pec_error === 1'b1) begin
            n_error_words++;
        end
        if (pending_readings.size() == 0) begin
            n_mismatches++;
            if (n_mismatches <= MAX_REPORTS) begin
                $display("unexpected word: idx %0d mv %0d aux %b err %b last %b",
                         got.value_index, got.millivolts, got.is_aux, got.pec_error,
                         got.last);
            end
        end else begin
            want = pending_readings.pop_front();
            if (got.value_index !== want.value_index || got.millivolts !== want.millivolts
                || got.is_aux !== want.is_aux || got.pec_error !== want.pec_error
                || got.last !== want.last) begin
                n_mismatches++;
                if (n_mismatches <= MAX_REPORTS) begin
                    $display("word %0d mismatch: exp idx %0d mv %0d aux %b err %b last %b",
                             n_results, want.value_index, want.millivolts, want.is_aux,
                             want.pec_error, want.last);
                    $display("                  got idx %0d mv %0d aux %b err %b last %b",
                             got.value_index, got.millivolts, got.is_aux, got.pec_error,
                             got.last);
                end
            end
        end
    endfunction

    // Receiver: random stall after each word taken
    always @(posedge i_clk) begin
        int unsigned nxt;
        if (!i_rst_n) begin
            pop      <= 1'b0;
            pop_wait <= 0;
        end else begin
            if (pop && !empty) begin
                check_reading(o_result);
                nxt = rx_no_stall ? 0 : $urandom_range(0, MAX_GAP);
            end else begin
                nxt = (pop_wait > 0) ? pop_wait - 1 : 0;
            end
            pop_wait <= nxt;
            pop      <= (nxt == 0);
        end
    end

    // Watchdog: no transfer on either side for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        idle_cycles = 0;
        // predictor reset state
        cfg_lsb_uv         = 100;
        cfg_cells_per_chip = 12;
        cfg_series_cells   = 12;
        rx_pos             = 0;
        rx_code            = 15'(PEC_SEED);
        rx_code_hi         = '0;
        foreach (rx_held[k]) begin
            rx_held[k] = '0;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_frames();
        test_config_extremes();
        test_result_backpressure();
        test_back_to_back();
        test_random_settings();
        wait_for_drain();

        $display("sent %0d frames in %0d bytes (%0d stray), %0d register settings",
                 n_frames, n_bytes, n_stray_bytes, n_settings);
        $display("checked %0d words, %0d code errors, %0d mismatches",
                 n_results, n_error_words, n_mismatches);
        if (n_mismatches == 0 && pending_readings.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
